// ----- rtl/cau_pkg.sv -----
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types, constants and tables of the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

  typedef enum logic [2:0] {
    MODE_ADD = 3'd0,
    MODE_SUB = 3'd1,
    MODE_MUL = 3'd2,
    MODE_DIV = 3'd3,
    MODE_MAG = 3'd4,
    MODE_ARG = 3'd5
  } mode_t;

  // angle accumulator, Q30, signed
  localparam int ZW = 34;
  localparam logic signed [ZW-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;

  // width of the per-item bundle that runs down the cell chain
  function automatic int st_width(input int w);
    return 18 * w + 20 + ZW;
  endfunction

  // atan(2^-i) in Q30
  function automatic logic [29:0] atan_q30(input int idx);
    logic [29:0] v;
    case (idx)
      0:       v = 30'd843314856;
      1:       v = 30'd497837829;
      2:       v = 30'd263043836;
      3:       v = 30'd133525159;
      4:       v = 30'd67021687;
      5:       v = 30'd33543516;
      6:       v = 30'd16775851;
      7:       v = 30'd8388437;
      8:       v = 30'd4194283;
      9:       v = 30'd2097149;
      10:      v = 30'd1048576;
      11:      v = 30'd524288;
      12:      v = 30'd262144;
      13:      v = 30'd131072;
      14:      v = 30'd65536;
      15:      v = 30'd32768;
      16:      v = 30'd16384;
      17:      v = 30'd8192;
      18:      v = 30'd4096;
      19:      v = 30'd2048;
      20:      v = 30'd1024;
      21:      v = 30'd512;
      22:      v = 30'd256;
      23:      v = 30'd128;
      24:      v = 30'd64;
      25:      v = 30'd32;
      26:      v = 30'd16;
      27:      v = 30'd8;
      28:      v = 30'd4;
      29:      v = 30'd2;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/complex_arithmetic_unit.sv -----
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Pipelined complex ALU: add, subtract, multiply, divide, magnitude, argument.
// ----------------------------------------------------------------------------
// Takes one transfer per clock and returns one result transfer per input, in
// order. Every item runs the same path: three front stages (products, sums,
// lane setup), a chain of max(DATA_WIDTH+1, CORDIC_STEPS) cells, and the
// output register. The cell count is set by the restoring divider, which
// resolves one quotient bit per cell over DATA_WIDTH+1 bits, or by CORDIC_STEPS
// where that is larger; the first DATA_WIDTH cells also give one square-root
// bit each, the first CORDIC_STEPS one CORDIC rotation each. The pipeline holds
// only while its last cell is full and the output register holds a result
// that has not been taken, so input is still accepted behind a waiting result.
// Operands and results are signed fixed point with FRAC_BITS fraction bits;
// out-of-range parts saturate and raise overflow, divide by zero gives zero
// with div_by_zero set.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit
  import cau_pkg::*;
#(
  parameter int DATA_WIDTH   = 32,
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 16,
  localparam int IN_W  = ((3 + 4 * DATA_WIDTH + 7) / 8) * 8,
  localparam int OUT_W = ((2 * DATA_WIDTH + 2 + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // mode[2:0], a_re, a_im, b_re, b_im, zero pad
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // res_re, res_im, div_by_zero, overflow, zero pad
  output logic [OUT_W-1:0] out_tdata
);

  localparam int W  = DATA_WIDTH;
  localparam int NC = (W + 1 > CORDIC_STEPS) ? W + 1 : CORDIC_STEPS;
  localparam int SW = st_width(W);

  logic          en;
  logic          vld_c [NC+1];
  logic [SW-1:0] st_c  [NC+1];
  logic [W-1:0]  res_re, res_im;
  logic          div_by_zero, overflow;

  // stall only when the last cell and the output register are both occupied
  assign en        = !(vld_c[NC] && out_tvalid && !out_tready);
  assign in_tready = en;

  cau_front #(
    .W (W),
    .F (FRAC_BITS)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (in_tvalid),
    .mode_i (in_tdata[2:0]),
    .a_re_i (in_tdata[3 +: W]),
    .a_im_i (in_tdata[3 + W +: W]),
    .b_re_i (in_tdata[3 + 2 * W +: W]),
    .b_im_i (in_tdata[3 + 3 * W +: W]),
    .vld_o  (vld_c[0]),
    .st_o   (st_c[0])
  );

  // a quotient bit, a root bit and a rotation per cell, each where the index applies
  for (genvar i = 0; i < NC; i++) begin : g_cell
    cau_cell #(
      .W   (W),
      .CS  (CORDIC_STEPS),
      .IDX (i)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .vld_i (vld_c[i]),
      .st_i  (st_c[i]),
      .vld_o (vld_c[i+1]),
      .st_o  (st_c[i+1])
    );
  end

  cau_back #(
    .W (W),
    .F (FRAC_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .vld_i       (vld_c[NC]),
    .st_i        (st_c[NC]),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .res_re      (res_re),
    .res_im      (res_im),
    .div_by_zero (div_by_zero),
    .overflow    (overflow)
  );

  assign out_tdata = {{(OUT_W - 2 * W - 2){1'b0}}, overflow, div_by_zero, res_im, res_re};

endmodule

// ----- rtl/cau_front.sv -----
// ----------------------------------------------------------------------------
// cau_front
// Three input stages: products, sums, then per-mode setup of the cell lanes.
// ----------------------------------------------------------------------------
module cau_front
  import cau_pkg::*;
#(
  parameter int W = 32,
  parameter int F = 16,
  localparam int SW = st_width(W)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          vld_i,
  input  logic [2:0]    mode_i,
  input  logic [W-1:0]  a_re_i,
  input  logic [W-1:0]  a_im_i,
  input  logic [W-1:0]  b_re_i,
  input  logic [W-1:0]  b_im_i,
  output logic          vld_o,
  output logic [SW-1:0] st_o
);

  localparam int P = 2 * W;

  typedef struct packed {
    mode_t                  mode;
    logic [W-1:0]           pre_re;
    logic [W-1:0]           pre_im;
    logic                   pre_ov;
    logic                   pre_dz;
    logic [P-1:0]           den;
    logic [P-1:0]           dr_re;
    logic [P-1:0]           dr_im;
    logic [W:0]             dl_re;
    logic [W:0]             dl_im;
    logic [W:0]             dq_re;
    logic [W:0]             dq_im;
    logic                   dn_re;
    logic                   dn_im;
    logic                   dov_re;
    logic                   dov_im;
    logic [P-1:0]           sq;
    logic [W+1:0]           rem;
    logic [W-1:0]           root;
    logic signed [W+1:0]    cx;
    logic signed [W+1:0]    cy;
    logic signed [ZW-1:0]   cz;
    logic                   skip;
  } st_t;

  localparam logic [P:0] MAXE = {{(P-W+2){1'b0}}, {(W-1){1'b1}}};
  localparam logic [P:0] MINE = {{(P-W+2){1'b1}}, {(W-1){1'b0}}};

  function automatic logic [P-1:0] clip(input logic [P:0] s);
    if (s[P] != s[P-1]) begin
      return s[P] ? {1'b1, {(P-1){1'b0}}} : {1'b0, {(P-1){1'b1}}};
    end
    return s[P-1:0];
  endfunction

  // {overflow, value}
  function automatic logic [W:0] sat(input logic [P:0] v);
    if ($signed(v) > $signed(MAXE)) begin
      return {1'b1, MAXE[W-1:0]};
    end
    if ($signed(v) < $signed(MINE)) begin
      return {1'b1, MINE[W-1:0]};
    end
    return {1'b0, v[W-1:0]};
  endfunction

  // stage 1: products
  logic                v1_r;
  logic [2:0]          m1_r;
  logic signed [W-1:0] ar1_r, ai1_r, br1_r, bi1_r;
  logic signed [P-1:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r;
  logic signed [P-1:0] p_bb_r, p_cc_r, p_aa_r, p_dd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_r   <= mode_i;
      ar1_r  <= $signed(a_re_i);
      ai1_r  <= $signed(a_im_i);
      br1_r  <= $signed(b_re_i);
      bi1_r  <= $signed(b_im_i);
      p_rr_r <= $signed(a_re_i) * $signed(b_re_i);
      p_ii_r <= $signed(a_im_i) * $signed(b_im_i);
      p_ri_r <= $signed(a_re_i) * $signed(b_im_i);
      p_ir_r <= $signed(a_im_i) * $signed(b_re_i);
      p_bb_r <= $signed(b_re_i) * $signed(b_re_i);
      p_cc_r <= $signed(b_im_i) * $signed(b_im_i);
      p_aa_r <= $signed(a_re_i) * $signed(a_re_i);
      p_dd_r <= $signed(a_im_i) * $signed(a_im_i);
    end
  end

  // stage 2: sums
  logic signed [P:0] mre_nxt, mim_nxt, dre_s, dim_s;
  logic signed [W:0] sre_nxt, sim_nxt;

  always_comb begin
    mre_nxt = (P+1)'(p_rr_r) - (P+1)'(p_ii_r);
    mim_nxt = (P+1)'(p_ri_r) + (P+1)'(p_ir_r);
    dre_s   = (P+1)'(p_rr_r) + (P+1)'(p_ii_r);
    dim_s   = (P+1)'(p_ir_r) - (P+1)'(p_ri_r);
    if (m1_r == MODE_SUB) begin
      sre_nxt = (W+1)'(ar1_r) - (W+1)'(br1_r);
      sim_nxt = (W+1)'(ai1_r) - (W+1)'(bi1_r);
    end else begin
      sre_nxt = (W+1)'(ar1_r) + (W+1)'(br1_r);
      sim_nxt = (W+1)'(ai1_r) + (W+1)'(bi1_r);
    end
  end

  logic                v2_r;
  logic [2:0]          m2_r;
  logic signed [W-1:0] ar2_r, ai2_r;
  logic [P:0]          mre2_r, mim2_r;
  logic [P-1:0]        dre2_r, dim2_r, den2_r, sq2_r;
  logic [W:0]          sre2_r, sim2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2_r   <= m1_r;
      ar2_r  <= ar1_r;
      ai2_r  <= ai1_r;
      mre2_r <= mre_nxt;
      mim2_r <= mim_nxt;
      dre2_r <= clip(dre_s);
      dim2_r <= clip(dim_s);
      den2_r <= p_bb_r + p_cc_r;
      sq2_r  <= p_aa_r + p_dd_r;
      sre2_r <= sre_nxt;
      sim2_r <= sim_nxt;
    end
  end

  // stage 3: lane setup
  st_t               s_nxt;
  logic [W:0]        sat_re, sat_im;
  logic [P:0]        rnd_re, rnd_im;
  logic [P-1:0]      mag_re, mag_im, hi_re, hi_im;
  logic signed [W+1:0] x0, y0;

  always_comb begin
    s_nxt      = '0;
    s_nxt.mode = mode_t'(m2_r);
    s_nxt.den  = den2_r;
    s_nxt.sq   = sq2_r;

    rnd_re = ($signed(mre2_r) >>> F) + $signed((P+1)'(mre2_r[F-1]));
    rnd_im = ($signed(mim2_r) >>> F) + $signed((P+1)'(mim2_r[F-1]));
    sat_re = '0;
    sat_im = '0;
    case (m2_r)
      MODE_ADD, MODE_SUB: begin
        sat_re = sat((P+1)'($signed(sre2_r)));
        sat_im = sat((P+1)'($signed(sim2_r)));
      end
      MODE_MUL: begin
        sat_re = sat(rnd_re);
        sat_im = sat(rnd_im);
      end
      default: ;
    endcase
    s_nxt.pre_re = sat_re[W-1:0];
    s_nxt.pre_im = sat_im[W-1:0];
    s_nxt.pre_ov = sat_re[W] | sat_im[W];
    s_nxt.pre_dz = (m2_r == MODE_DIV) && (den2_r == '0);

    // divider lanes: magnitude, high part as first remainder, low bits to shift in
    mag_re       = dre2_r[P-1] ? P'(-dre2_r) : dre2_r;
    mag_im       = dim2_r[P-1] ? P'(-dim2_r) : dim2_r;
    hi_re        = mag_re >> (W - F);
    hi_im        = mag_im >> (W - F);
    s_nxt.dn_re  = dre2_r[P-1];
    s_nxt.dn_im  = dim2_r[P-1];
    s_nxt.dov_re = hi_re >= den2_r;
    s_nxt.dov_im = hi_im >= den2_r;
    s_nxt.dr_re  = hi_re;
    s_nxt.dr_im  = hi_im;
    s_nxt.dl_re  = (W+1)'(mag_re << (F + 1));
    s_nxt.dl_im  = (W+1)'(mag_im << (F + 1));

    // CORDIC start: axes are exact, left half-plane turned by pi
    x0 = (W+2)'(ar2_r);
    y0 = (W+2)'(ai2_r);
    s_nxt.cx = x0;
    s_nxt.cy = y0;
    if (ai2_r == '0) begin
      s_nxt.skip = 1'b1;
      s_nxt.cz   = ar2_r[W-1] ? PI_Q30 : '0;
    end else if (ar2_r == '0) begin
      s_nxt.skip = 1'b1;
      s_nxt.cz   = ai2_r[W-1] ? -HALF_PI_Q30 : HALF_PI_Q30;
    end else if (ar2_r[W-1]) begin
      s_nxt.cz = ai2_r[W-1] ? -PI_Q30 : PI_Q30;
      s_nxt.cx = -x0;
      s_nxt.cy = -y0;
    end
  end

  logic      v3_r;
  st_t       st3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st3_r <= s_nxt;
    end
  end

  assign vld_o = v3_r;
  assign st_o  = st3_r;

endmodule

// ----- rtl/cau_cell.sv -----
// ----------------------------------------------------------------------------
// cau_cell
// One step of the chain: a quotient bit on both divider lanes, a root bit
// and one CORDIC micro-rotation, each only where this cell's index applies.
// ----------------------------------------------------------------------------
module cau_cell
  import cau_pkg::*;
#(
  parameter int W   = 32,
  parameter int CS  = 16,
  parameter int IDX = 0,
  localparam int SW = st_width(W)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          vld_i,
  input  logic [SW-1:0] st_i,
  output logic          vld_o,
  output logic [SW-1:0] st_o
);

  localparam int P = 2 * W;

  typedef struct packed {
    mode_t                  mode;
    logic [W-1:0]           pre_re;
    logic [W-1:0]           pre_im;
    logic                   pre_ov;
    logic                   pre_dz;
    logic [P-1:0]           den;
    logic [P-1:0]           dr_re;
    logic [P-1:0]           dr_im;
    logic [W:0]             dl_re;
    logic [W:0]             dl_im;
    logic [W:0]             dq_re;
    logic [W:0]             dq_im;
    logic                   dn_re;
    logic                   dn_im;
    logic                   dov_re;
    logic                   dov_im;
    logic [P-1:0]           sq;
    logic [W+1:0]           rem;
    logic [W-1:0]           root;
    logic signed [W+1:0]    cx;
    logic signed [W+1:0]    cy;
    logic signed [ZW-1:0]   cz;
    logic                   skip;
  } st_t;

  // {remainder, low bits, quotient}
  function automatic logic [P+2*W+1:0] div_step(input logic [P-1:0] r, input logic [W:0] l,
                                               input logic [W:0] q, input logic [P-1:0] d);
    logic [P:0] r2;
    logic       bt;
    r2 = {r, l[W]};
    bt = r2 >= {1'b0, d};
    if (bt) begin
      r2 = r2 - {1'b0, d};
    end
    return {r2[P-1:0], l[W-1:0], 1'b0, q[W-1:0], bt};
  endfunction

  st_t                 s, n;
  logic [W+3:0]        rem2, trial;
  logic signed [W+1:0] dx, dy;
  logic signed [ZW-1:0] at;

  always_comb begin
    s = st_t'(st_i);
    n = s;

    if (IDX <= W) begin
      {n.dr_re, n.dl_re, n.dq_re} = div_step(s.dr_re, s.dl_re, s.dq_re, s.den);
      {n.dr_im, n.dl_im, n.dq_im} = div_step(s.dr_im, s.dl_im, s.dq_im, s.den);
    end

    rem2  = {s.rem, s.sq[P-1:P-2]};
    trial = {2'b00, s.root, 2'b01};
    if (IDX < W) begin
      n.sq = {s.sq[P-3:0], 2'b00};
      if (rem2 >= trial) begin
        n.rem  = (W+2)'(rem2 - trial);
        n.root = {s.root[W-2:0], 1'b1};
      end else begin
        n.rem  = (W+2)'(rem2);
        n.root = {s.root[W-2:0], 1'b0};
      end
    end

    dx = s.cy >>> IDX;
    dy = s.cx >>> IDX;
    at = ZW'(atan_q30(IDX));
    if (IDX < CS && !s.skip) begin
      if (!s.cy[W+1]) begin
        n.cx = s.cx + dx;
        n.cy = s.cy - dy;
        n.cz = s.cz + at;
      end else begin
        n.cx = s.cx - dx;
        n.cy = s.cy + dy;
        n.cz = s.cz - at;
      end
    end
  end

  logic vld_r;
  st_t  st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= n;
    end
  end

  assign vld_o = vld_r;
  assign st_o  = st_r;

endmodule

// ----- rtl/cau_back.sv -----
// ----------------------------------------------------------------------------
// cau_back
// Final rounding and saturation per mode, and the output register.
// ----------------------------------------------------------------------------
module cau_back
  import cau_pkg::*;
#(
  parameter int W = 32,
  parameter int F = 16,
  localparam int SW = st_width(W)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          vld_i,
  input  logic [SW-1:0] st_i,
  input  logic          out_tready,
  output logic          out_tvalid,
  output logic [W-1:0]  res_re,
  output logic [W-1:0]  res_im,
  output logic          div_by_zero,
  output logic          overflow
);

  localparam int P  = 2 * W;
  localparam int S  = 30 - F;
  localparam int SI = (S > 0) ? S - 1 : 0;
  localparam int EW = ((ZW > W) ? ZW : W) + 1;

  typedef struct packed {
    mode_t                  mode;
    logic [W-1:0]           pre_re;
    logic [W-1:0]           pre_im;
    logic                   pre_ov;
    logic                   pre_dz;
    logic [P-1:0]           den;
    logic [P-1:0]           dr_re;
    logic [P-1:0]           dr_im;
    logic [W:0]             dl_re;
    logic [W:0]             dl_im;
    logic [W:0]             dq_re;
    logic [W:0]             dq_im;
    logic                   dn_re;
    logic                   dn_im;
    logic                   dov_re;
    logic                   dov_im;
    logic [P-1:0]           sq;
    logic [W+1:0]           rem;
    logic [W-1:0]           root;
    logic signed [W+1:0]    cx;
    logic signed [W+1:0]    cy;
    logic signed [ZW-1:0]   cz;
    logic                   skip;
  } st_t;

  localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
  localparam logic [EW-1:0] MAXE = {{(EW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [EW-1:0] MINE = {{(EW-W+1){1'b1}}, {(W-1){1'b0}}};

  // quotient rounding (half away from zero on the magnitude), sign and clamp
  function automatic logic [W:0] div_fin(input logic [W:0] q, input logic neg,
                                         input logic pov);
    logic [W+1:0] qs;
    logic [W:0]   qf;
    qs = {1'b0, q} + (W+2)'(1);
    qf = qs[W+1:1];
    if (pov) begin
      return {1'b1, neg ? MINV : MAXV};
    end
    if (neg) begin
      if (qf > {2'b01, {(W-1){1'b0}}}) begin
        return {1'b1, MINV};
      end
      return {1'b0, W'(-qf)};
    end
    if (qf > {1'b0, MAXV}) begin
      return {1'b1, MAXV};
    end
    return {1'b0, qf[W-1:0]};
  endfunction

  st_t                  s;
  logic [W:0]           fre, fim, rr;
  logic signed [ZW-1:0] zr;
  logic signed [EW-1:0] ze;
  logic [W-1:0]         re_nxt, im_nxt;
  logic                 dz_nxt, ov_nxt;

  always_comb begin
    s   = st_t'(st_i);
    fre = div_fin(s.dq_re, s.dn_re, s.dov_re);
    fim = div_fin(s.dq_im, s.dn_im, s.dov_im);
    rr  = {1'b0, s.root} + (W+1)'(s.rem > {2'b00, s.root});
    if (S == 0) begin
      zr = s.cz;
    end else begin
      zr = (s.cz >>> S) + $signed(ZW'(s.cz[SI]));
    end
    ze = EW'(zr);

    re_nxt = s.pre_re;
    im_nxt = s.pre_im;
    dz_nxt = s.pre_dz;
    ov_nxt = s.pre_ov;
    case (s.mode)
      MODE_DIV: begin
        if (!s.pre_dz) begin
          re_nxt = fre[W-1:0];
          im_nxt = fim[W-1:0];
          ov_nxt = fre[W] | fim[W];
        end
      end
      MODE_MAG: begin
        im_nxt = '0;
        ov_nxt = rr > {1'b0, MAXV};
        re_nxt = ov_nxt ? MAXV : rr[W-1:0];
      end
      MODE_ARG: begin
        im_nxt = '0;
        ov_nxt = ($signed(ze) > $signed(MAXE)) || ($signed(ze) < $signed(MINE));
        if ($signed(ze) > $signed(MAXE)) begin
          re_nxt = MAXV;
        end else if ($signed(ze) < $signed(MINE)) begin
          re_nxt = MINV;
        end else begin
          re_nxt = ze[W-1:0];
        end
      end
      default: ;
    endcase
  end

  logic         vld_r;
  logic [W-1:0] re_r, im_r;
  logic         dz_r, ov_r;
  logic         ld;

  assign ld = !vld_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ld) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      re_r <= re_nxt;
      im_r <= im_nxt;
      dz_r <= dz_nxt;
      ov_r <= ov_nxt;
    end
  end

  assign out_tvalid  = vld_r;
  assign res_re      = re_r;
  assign res_im      = im_r;
  assign div_by_zero = dz_r;
  assign overflow    = ov_r;

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for complex_arithmetic_unit.
// ----------------------------------------------------------------------------
// A directed table covers the field extremes, every mode, both unused codes
// and the special cases: divide by zero, argument of zero, exact axes and
// saturation. Random items follow. Each accepted input transfer queues its
// typed or predicted result. Each output transfer is compared with the oldest.
// Both sides idle at random, and one long receiver hold-off backs up the pipe.
// ----------------------------------------------------------------------------
module tb_top
  import cau_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IN_W  = 136;
  localparam int OUT_W = 72;
  localparam int N_RANDOM = 630;
  localparam int IDLE_LIMIT = 20000;   // cycles with no transfer on either side
  localparam int DRAIN_CYCLES = 60;
  localparam logic [2:0] MODE_RSVD6 = 3'd6;
  localparam logic [2:0] MODE_RSVD7 = 3'd7;
  localparam longint QMAX = 64'sd2147483647;
  localparam longint QMIN = -64'sd2147483648;
  localparam logic signed [31:0] ONE = 32'sd65536;

  typedef struct {
    logic [2:0]  mode;
    logic [31:0] a_re, a_im, b_re, b_im;
  } op_item_t;

  typedef struct {
    logic [31:0] re, im;
    logic        dz, ov;
  } cplx_res_t;

  typedef struct {
    op_item_t  op;
    bit        typed;     // expectation typed into the row
    cplx_res_t res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  cplx_res_t result_fifo[$];
  stim_row_t directed[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit hold_done = 1'b0;

  complex_arithmetic_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint sat_q(input longint v, inout bit ov);
    if (v > QMAX) begin
      ov = 1'b1;
      return QMAX;
    end
    if (v < QMIN) begin
      ov = 1'b1;
      return QMIN;
    end
    return v;
  endfunction

  // 64-bit sum with clipping at the int64 limits
  function automatic longint sum_clip(input longint x, input longint y);
    logic signed [65:0] t;
    t = x;
    t = t + y;
    if (t > 66'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (t < -66'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
    return t[63:0];
  endfunction

  function automatic longint quot_q(input longint num, input bit [63:0] den, inout bit ov);
    bit neg;
    bit [63:0] m, q, r;
    neg = num < 0;
    m = neg ? 64'(-num) : 64'(num);
    q = m / den;
    r = m % den;
    if (q >= (64'd1 << 46)) begin
      ov = 1'b1;
      return neg ? QMIN : QMAX;
    end
    for (int k = 0; k <= 16; k++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q[0] = 1'b1;
      end
    end
    q = (q + 64'd1) >> 1;
    return sat_q(neg ? -longint'(q) : longint'(q), ov);
  endfunction

  function automatic longint phase_q(input longint x, input longint y);
    longint z, dx, dy;
    z = 0;
    if (y == 0) z = (x < 0) ? 64'(PI_Q30) : 0;
    else if (x == 0) z = (y > 0) ? 64'(HALF_PI_Q30) : -64'(HALF_PI_Q30);
    else begin
      if (x < 0) begin
        z = (y >= 0) ? 64'(PI_Q30) : -64'(PI_Q30);
        x = -x;
        y = -y;
      end
      for (int i = 0; i < 16; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x += dx; y -= dy; z += longint'(atan_q30(i));
        end else begin
          x -= dx; y += dy; z -= longint'(atan_q30(i));
        end
      end
    end
    return (z >>> 14) + ((z >>> 13) & 1);
  endfunction

  function automatic cplx_res_t predict_cplx(input op_item_t op);
    cplx_res_t rs;
    longint ar, ai, br, bi, re, im, s;
    bit [63:0] den, sq, rt, bt;
    bit ov;
    ar = longint'($signed(op.a_re));
    ai = longint'($signed(op.a_im));
    br = longint'($signed(op.b_re));
    bi = longint'($signed(op.b_im));
    re = 0; im = 0; ov = 1'b0;
    rs.dz = 1'b0;
    case (op.mode)
      MODE_ADD: begin
        re = sat_q(ar + br, ov);
        im = sat_q(ai + bi, ov);
      end
      MODE_SUB: begin
        re = sat_q(ar - br, ov);
        im = sat_q(ai - bi, ov);
      end
      MODE_MUL: begin
        s = sum_clip(ar * br, -(ai * bi));
        re = sat_q((s >>> 16) + ((s >>> 15) & 1), ov);
        s = sum_clip(ar * bi, ai * br);
        im = sat_q((s >>> 16) + ((s >>> 15) & 1), ov);
      end
      MODE_DIV: begin
        den = 64'(br * br) + 64'(bi * bi);
        if (den == 0) rs.dz = 1'b1;
        else begin
          re = quot_q(sum_clip(ar * br, ai * bi), den, ov);
          im = quot_q(sum_clip(ai * br, -(ar * bi)), den, ov);
        end
      end
      MODE_MAG: begin
        sq = 64'(ar * ar) + 64'(ai * ai);
        rt = 0;
        bt = 64'd1 << 62;
        while (bt > sq) bt = bt >> 2;
        while (bt != 0) begin
          if (sq >= rt + bt) begin
            sq = sq - (rt + bt);
            rt = (rt >> 1) + bt;
          end else rt = rt >> 1;
          bt = bt >> 2;
        end
        // sq now holds the remainder n - r*r
        if (sq > rt) rt = rt + 1;
        re = sat_q(longint'(rt), ov);
      end
      MODE_ARG: re = sat_q(phase_q(ar, ai), ov);
      default: ;
    endcase
    rs.re = re[31:0];
    rs.im = im[31:0];
    rs.ov = ov;
    return rs;
  endfunction

  // ---------------------------------------------------------------- helpers
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2, 3: return 32'($signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000);
      4:    return {16'($urandom_range(0, 255)), 16'h0} ^
                   ($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0);
      default: begin
        case ($urandom_range(0, 3))
          0: return 32'h0;
          1: return 32'h7FFF_FFFF;
          2: return 32'h8000_0000;
          default: return 32'h0001_0000;
        endcase
      end
    endcase
  endfunction

  function automatic op_item_t pick_item();
    op_item_t op;
    int p;
    p = $urandom_range(0, 99);
    op.mode = (p < 4) ? ($urandom_range(0, 1) ? MODE_RSVD6 : MODE_RSVD7)
                      : 3'($urandom_range(0, 5));
    op.a_re = pick_operand();
    op.a_im = pick_operand();
    op.b_re = pick_operand();
    op.b_im = pick_operand();
    // a share of divides by zero and axis arguments
    if (op.mode == MODE_DIV && $urandom_range(0, 9) == 0) begin
      op.b_re = '0; op.b_im = '0;
    end
    if (op.mode == MODE_ARG && $urandom_range(0, 7) == 0) begin
      if ($urandom_range(0, 1)) op.a_re = '0; else op.a_im = '0;
    end
    return op;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("[%0t] MISMATCH %s: got %h want %h", $realtime, what, got, want);
  endtask

  function automatic void add_row(input logic [2:0] m, input logic [31:0] ar, ai, br, bi,
                                  input bit typed, input logic [31:0] re = 0,
                                  input logic [31:0] im = 0, input logic dz = 0,
                                  input logic ov = 0);
    stim_row_t row;
    row.op.mode = m;
    row.op.a_re = ar; row.op.a_im = ai; row.op.b_re = br; row.op.b_im = bi;
    row.typed = typed;
    row.res.re = re; row.res.im = im; row.res.dz = dz; row.res.ov = ov;
    directed.push_back(row);
  endfunction

  // one input transfer; the gap is taken before raising valid
  task automatic send_item(input op_item_t op, input bit typed, input cplx_res_t want,
                           input bit no_gap);
    int gap;
    gap = no_gap ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {5'b0, op.b_im, op.b_re, op.a_im, op.a_re, op.mode};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    result_fifo.push_back(typed ? want : predict_cplx(op));
  endtask

  // ---------------------------------------------------------------- stimulus
  initial begin
    cplx_res_t none;
    none = '{default: '0};
    // expected values typed in: trivial sums, saturation, flags, axes
    add_row(MODE_ADD, 0, 0, 0, 0, 1);
    add_row(MODE_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 1,
            32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 1);
    add_row(MODE_SUB, 32'h8000_0000, 32'h8000_0000, 1, 32'h8000_0000, 1,
            32'h8000_0000, 0, 0, 1);
    add_row(MODE_MUL, ONE, 0, ONE, 0, 1, 32'h0001_0000, 0, 0, 0);
    add_row(MODE_DIV, 32'h1234_5678, 32'h8000_0000, 0, 0, 1, 0, 0, 1, 0);
    add_row(MODE_MAG, 3 * ONE, 4 * ONE, 32'hFFFF_FFFF, 32'h8000_0000, 1, 5 * ONE, 0, 0, 0);
    add_row(MODE_ARG, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1);
    add_row(MODE_ARG, 1, 0, 0, 0, 1);
    add_row(MODE_ARG, 32'hFFFF_FFFF, 0, 0, 0, 1, 32'd205887);
    add_row(MODE_ARG, 0, 1, 0, 0, 1, 32'd102944);
    add_row(MODE_ARG, 0, 32'h8000_0000, 0, 0, 1, -32'sd102944);
    add_row(MODE_RSVD6, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1, 1);
    add_row(MODE_RSVD7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
    // predicted: extremes through the multiplier, divider, root and CORDIC
    add_row(MODE_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 0);
    add_row(MODE_MUL, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0);
    add_row(MODE_MUL, 32'h0000_8000, 0, 1, 0, 0);
    add_row(MODE_DIV, 32'h8000_0000, 32'h8000_0000, 1, 0, 0);
    add_row(MODE_DIV, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 0);
    add_row(MODE_DIV, ONE, ONE, 3 * ONE, -32'sd7 * ONE, 0);
    add_row(MODE_MAG, 32'h8000_0000, 32'h8000_0000, 0, 0, 0);
    add_row(MODE_MAG, 32'h7FFF_FFFF, 0, 0, 0, 0);
    add_row(MODE_ARG, ONE, ONE, 0, 0, 0);
    add_row(MODE_ARG, -32'sd5 * ONE, 2 * ONE, 0, 0, 0);
    add_row(MODE_ARG, -32'sd5 * ONE, -32'sd2 * ONE, 0, 0, 0);
    add_row(MODE_ARG, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_item(directed[i].op, directed[i].typed, directed[i].res, 0);
    for (int i = 0; i < N_RANDOM; i++) begin
      // every third block of 40 items streams back to back
      send_item(pick_item(), 0, none, ((i / 40) % 3) == 1);
    end
    in_tvalid <= 1'b0;

    while (result_fifo.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("complex_arithmetic_unit verification clean");
    else $display("complex_arithmetic_unit verification failed");
    $finish;
  end

  // ---------------------------------------------------------------- receiver
  // Random stalls, a few long, stretches with none, and one very long hold-off
  // while the input keeps offering items so the pipe fills and drops in_tready.
  initial begin
    int stall;
    int cyc;
    stall = 0;
    cyc = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (!hold_done && cyc == 400) begin
        hold_done = 1'b1;
        stall = 300;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else if (((cyc / 150) % 3) == 2) begin
        out_tready <= 1'b1;   // stretch with no stalls
      end else begin
        stall = pick_gap();
        out_tready <= (stall == 0);
        if (stall > 0) stall--;
      end
    end
  end

  // ---------------------------------------------------------------- checker
  always @(posedge clk) begin
    cplx_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (result_fifo.size() == 0) begin
        mismatches++;
        $display("[%0t] MISMATCH unexpected result transfer %h", $realtime, out_tdata);
      end else begin
        want = result_fifo.pop_front();
        if (out_tdata[31:0] !== want.re) report_mismatch("res_re", out_tdata[31:0], want.re);
        if (out_tdata[63:32] !== want.im) report_mismatch("res_im", out_tdata[63:32], want.im);
        if (out_tdata[64] !== want.dz) report_mismatch("div_by_zero", 32'(out_tdata[64]), 32'(want.dz));
        if (out_tdata[65] !== want.ov) report_mismatch("overflow", 32'(out_tdata[65]), 32'(want.ov));
      end
    end
  end

  // ---------------------------------------------------------------- watchdog
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("complex_arithmetic_unit verification failed");
      $finish;
    end
  end

endmodule

// ----- filelist.f -----
rtl/cau_pkg.sv
rtl/cau_front.sv
rtl/cau_cell.sv
rtl/cau_back.sv
rtl/complex_arithmetic_unit.sv
test/tb_top.sv
